// ===== src/iostk_pkg.sv =====
// Shared types and constants for the indexed object stack.
// No dependencies; imported by every module of the block.
package iostk_pkg;

  localparam int DepthDef = 1024;
  localparam int DataW    = 64;
  localparam int IdxW     = 10;
  localparam int CmdW     = 3;
  localparam int StW      = 2;
  localparam int DnW      = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_RD_TOP = 3'd2,
    CMD_RD_BOT = 3'd3,
    CMD_WR_TOP = 3'd4,
    CMD_WR_BOT = 3'd5
  } cmd_t;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_UNDER = 2'd1;
  localparam logic [StW-1:0] ST_OVER  = 2'd2;

  // Memory access strobe from control to store
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  // Per-item result fields, minus the data word
  typedef struct packed {
    logic [StW-1:0] status;
    logic [DnW-1:0] depth_now;
    logic           rd;
  } res_t;

endpackage

// ===== src/iostk_mem.sv =====
// Element store: single-port synchronous RAM, registered read data.
// Depends on iostk_pkg.
module iostk_mem #(
  parameter int DEPTH  = iostk_pkg::DepthDef,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  iostk_pkg::mem_ctl_t        ctl,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [iostk_pkg::DataW-1:0] wdata,
  output logic [iostk_pkg::DataW-1:0] rdata
);
  import iostk_pkg::*;

  logic [DataW-1:0] mem_r [DEPTH];
  logic [DataW-1:0] rdata_r;

  // rdata_r only moves on a read, so it holds while the output stalls
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/iostk_ctrl.sv =====
// Stack control: element count, command decode, bounds checks, slot address.
// Depends on iostk_pkg; drives the iostk_mem access port.
module iostk_ctrl #(
  parameter int DEPTH  = iostk_pkg::DepthDef,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [iostk_pkg::CmdW-1:0]  cmd,
  input  logic [iostk_pkg::IdxW-1:0]  index,
  output iostk_pkg::mem_ctl_t         mem_ctl,
  output logic [ADDR_W-1:0]           mem_addr,
  output iostk_pkg::res_t             res
);
  import iostk_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IdxW) ? CNT_W : IdxW;
  localparam int EXT_W = (CNT_W > DnW) ? CNT_W : DnW;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0] idx_ext, cnt_cmp, slot_top;
  logic [EXT_W-1:0] cnt_ext;
  logic             in_range, full, empty;
  logic [StW-1:0]   status;
  logic             acc, wr;

  assign idx_ext  = CMP_W'(index);
  assign cnt_cmp  = CMP_W'(count_r);
  assign in_range = idx_ext < cnt_cmp;
  assign slot_top = cnt_cmp - CMP_W'(1) - idx_ext;
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    acc       = 1'b0;
    wr        = 1'b0;
    mem_addr  = '0;
    unique case (cmd_t'(cmd)) inside
      CMD_PUSH: begin
        if (full) begin
          status = ST_OVER;
        end else begin
          acc       = 1'b1;
          wr        = 1'b1;
          mem_addr  = count_r[ADDR_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          acc       = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          mem_addr  = count_nxt[ADDR_W-1:0];
        end
      end
      CMD_RD_TOP, CMD_RD_BOT, CMD_WR_TOP, CMD_WR_BOT: begin
        if (!in_range) begin
          status = ST_UNDER;
        end else begin
          acc = 1'b1;
          wr  = (cmd_t'(cmd) == CMD_WR_TOP) || (cmd_t'(cmd) == CMD_WR_BOT);
          if ((cmd_t'(cmd) == CMD_RD_TOP) || (cmd_t'(cmd) == CMD_WR_TOP)) begin
            mem_addr = slot_top[ADDR_W-1:0];
          end else begin
            mem_addr = idx_ext[ADDR_W-1:0];
          end
        end
      end
      default: status = ST_UNDER;
    endcase
  end

  assign cnt_ext       = EXT_W'(count_nxt);
  assign mem_ctl.en    = fire && acc;
  assign mem_ctl.we    = wr;
  assign res.status    = status;
  assign res.depth_now = cnt_ext[DnW-1:0];
  assign res.rd        = acc && !wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count beyond capacity");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("element count moved without an item");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (cmd == CMD_PUSH) && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.en |-> status == ST_OK)
    else $error("store accessed by a failing item");

  a_fail_keep: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status != ST_OK) |=> count_r == $past(count_r))
    else $error("failing item changed the count");
`endif

endmodule

// ===== src/indexed_object_stack_top.sv =====
// Indexed object stack, top level: control, element store and output register.
// Depends on iostk_pkg, iostk_ctrl and iostk_mem.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_ready, cmd, index, value    | request item in
//   out     | out_valid/out_ready, data, status,      | result item out
//           | depth_now                               |
//
// One item per cycle unless a result stalls; each result appears in the cycle
// after its item is taken, via the registered read; one store access at most.
// Reset clears the count and the output valid; the store is not cleared.
// A stalled result blocks new items only while it is held in the output stage.
module indexed_object_stack_top #(
  parameter int DEPTH = iostk_pkg::DepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [iostk_pkg::CmdW-1:0]   in_cmd,
  input  logic [iostk_pkg::IdxW-1:0]   in_index,
  input  logic [iostk_pkg::DataW-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iostk_pkg::DataW-1:0]  out_data,
  output logic [iostk_pkg::StW-1:0]    out_status,
  output logic [iostk_pkg::DnW-1:0]    out_depth_now
);
  import iostk_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic              fire;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [DataW-1:0]  rdata;
  res_t              res, res_r;
  logic              out_valid_r;

  // no item is taken while reset is held
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign fire     = in_valid && in_ready;

  iostk_ctrl #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .cmd      (in_cmd),
    .index    (in_index),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .res      (res)
  );

  iostk_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (in_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = res_r.rd ? rdata : '0;
  assign out_status    = res_r.status;
  assign out_depth_now = res_r.depth_now;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken over a stalled result");

  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.rd |-> out_status == ST_OK)
    else $error("read data on a failing result");
`endif

endmodule
